// ===== src/csh_pkg.sv =====
// shared constants for the cyclic shift hopping index block
// no dependencies; imported by cyclic_shift_hopping_index, csh_gold and the bench
package csh_pkg;

  localparam int unsigned SymbolsPerSlotDef = 14;
  localparam int unsigned BitsPerShift      = 8;
  localparam int unsigned GoldWarmup        = 1600;
  localparam int unsigned ShiftModulus      = 12;
  localparam int unsigned GroupCount        = 30;
  localparam int unsigned MaxNumerology     = 4;
  localparam int unsigned BaseSlots         = 10;
  localparam int unsigned MaxSlots          = BaseSlots << MaxNumerology;

  localparam int unsigned GoldLen    = 31;
  localparam int unsigned SlotW      = 16;
  localparam int unsigned SymW       = 4;
  localparam int unsigned ShiftW     = 4;
  localparam int unsigned IdentityW  = 10;
  localparam int unsigned NumerW     = 3;
  localparam int unsigned HopW       = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 10;
  localparam int unsigned SlotRemW   = $clog2(MaxSlots + 1);
  localparam int unsigned AlphaNumW  = $clog2(2 * 15 + 255 + 1);
  localparam int unsigned GroupW     = 5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_IDENTITY   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_NUMEROLOGY = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOPPING    = 2'd2;

  // hopping mode codes
  localparam logic [HopW-1:0] HOP_NEITHER = 2'd0;

  // status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOSUP = 1'b1;

endpackage

// ===== src/cyclic_shift_hopping_index.sv =====
// Cyclic-shift hopping index for one uplink control symbol. One word is worked on at a time:
// the slot number is reduced first, then the gold sequence generator steps one bit
// per cycle through 1600 warm-up bits plus 8*(SYMBOLS_PER_SLOT*n_slot + l + l') position
// bits and eight result bits, then a reduction modulo twelve follows. A finished result
// waits in the output register and a new word is taken once the block is idle again.
// Depends on csh_pkg, csh_mod and csh_gold.
module cyclic_shift_hopping_index import csh_pkg::*; #(
  parameter int unsigned SYMBOLS_PER_SLOT = SymbolsPerSlotDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SlotW-1:0]     slot_number_i,
  input  logic [SymW-1:0]      symbol_offset_i,
  input  logic [SymW-1:0]      start_symbol_i,
  input  logic [ShiftW-1:0]    initial_shift_i,
  input  logic [ShiftW-1:0]    shift_offset_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ShiftW-1:0]    alpha_index_o,
  output logic [GroupW-1:0]    group_number_o,
  output logic                 base_sequence_number_o,
  output logic                 status_o
);

  localparam int unsigned MaxSym = SYMBOLS_PER_SLOT * (MaxSlots - 1) + 2 * 15;
  localparam int unsigned TotW   = $clog2(GoldWarmup + BitsPerShift * MaxSym + 1);
  localparam int unsigned ModW   = $clog2(ShiftModulus + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_POS   = 3'd2;
  localparam logic [2:0] ST_GOLD  = 3'd3;
  localparam logic [2:0] ST_ALPHA = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [IdentityW-1:0] ident_q;
  logic [NumerW-1:0]    numer_q;
  logic [HopW-1:0]      hop_q;

  logic [SymW-1:0]      sym_l_q, sym_lp_q;
  logic [ShiftW-1:0]    m0_q, mcs_q;
  logic [SlotRemW-1:0]  nslot_q;
  logic [GroupW-1:0]    grp_rem_q;

  logic                 out_valid_q;
  logic [ShiftW-1:0]    alpha_q;
  logic [GroupW-1:0]    group_q;
  logic                 status_q;

  logic                 in_take, out_free;
  logic [NumerW-1:0]    mu;
  logic [SlotRemW-1:0]  slots;
  logic [TotW-1:0]      skip;
  logic [AlphaNumW-1:0] alpha_num;

  logic                 slot_done, grp_done, gold_done, alpha_done;
  logic [SlotRemW-1:0]  slot_rem;
  logic [GroupW-1:0]    grp_rem;
  logic [ModW-1:0]      alpha_rem;
  logic [BitsPerShift-1:0] gold_bits;
  logic                 ok;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign mu    = (numer_q > NumerW'(MaxNumerology)) ? NumerW'(MaxNumerology) : numer_q;
  assign slots = SlotRemW'(SlotRemW'(BaseSlots) << mu);

  // bit position of the first shift bit, plus the warm-up
  assign skip = TotW'(GoldWarmup)
              + ((TotW'(SYMBOLS_PER_SLOT) * TotW'(nslot_q)
                  + TotW'(sym_l_q) + TotW'(sym_lp_q)) << $clog2(BitsPerShift));

  assign alpha_num = AlphaNumW'(m0_q) + AlphaNumW'(mcs_q) + AlphaNumW'(gold_bits);
  assign ok        = hop_q == HOP_NEITHER;

  csh_mod #(.NUM_W(SlotW), .DIV_W(SlotRemW)) u_slot_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_take),
    .num_i   (slot_number_i),
    .div_i   (slots),
    .done_o  (slot_done),
    .rem_o   (slot_rem)
  );

  csh_mod #(.NUM_W(IdentityW), .DIV_W(GroupW)) u_grp_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_take),
    .num_i   (ident_q),
    .div_i   (GroupW'(GroupCount)),
    .done_o  (grp_done),
    .rem_o   (grp_rem)
  );

  csh_gold #(.TOT_W(TotW)) u_gold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_POS),
    .seed_i  (ident_q),
    .skip_i  (skip),
    .done_o  (gold_done),
    .bits_o  (gold_bits)
  );

  csh_mod #(.NUM_W(AlphaNumW), .DIV_W(ModW)) u_alpha_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_GOLD && gold_done),
    .num_i   (alpha_num),
    .div_i   (ModW'(ShiftModulus)),
    .done_o  (alpha_done),
    .rem_o   (alpha_rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_take) state_d = ST_MOD;
      end
      // group reduction is shorter, it is done by the time the slot is
      ST_MOD: begin
        if (slot_done) state_d = ST_POS;
      end
      ST_POS: begin
        state_d = ST_GOLD;
      end
      ST_GOLD: begin
        if (gold_done) state_d = ST_ALPHA;
      end
      ST_ALPHA: begin
        if (alpha_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ident_q     <= '0;
      numer_q     <= '0;
      hop_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IDENTITY:   ident_q <= cfg_data_i[IdentityW-1:0];
          CFG_NUMEROLOGY: numer_q <= cfg_data_i[NumerW-1:0];
          CFG_HOPPING:    hop_q   <= cfg_data_i[HopW-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sym_l_q  <= symbol_offset_i;
      sym_lp_q <= start_symbol_i;
      m0_q     <= initial_shift_i;
      mcs_q    <= shift_offset_i;
    end
    if (state_q == ST_MOD && slot_done) begin
      nslot_q <= slot_rem;
    end
    if (grp_done) begin
      grp_rem_q <= grp_rem;
    end
    if (state_q == ST_OUT && out_free) begin
      alpha_q  <= ShiftW'(alpha_rem);
      group_q  <= ok ? grp_rem_q : '0;
      status_q <= ok ? STATUS_OK : STATUS_NOSUP;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign alpha_index_o          = alpha_q;
  assign group_number_o         = group_q;
  assign base_sequence_number_o = 1'b0;
  assign status_o               = status_q;

endmodule

// ===== src/csh_mod.sv =====
// bit-serial restoring remainder unit, one numerator bit per cycle
// depends on nothing; used by the top level for the slot, group and alpha reductions
module csh_mod #(
  parameter int unsigned NUM_W = 16,
  parameter int unsigned DIV_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DIV_W-1:0] div_i,
  output logic             done_o,
  output logic [DIV_W-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W:0]   trial;
  logic             ge;
  logic             last;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, div_i};
  assign last  = cnt_q == CntW'(NUM_W - 1);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift the next numerator bit in, subtract where it fits
      rem_d = ge ? DIV_W'(trial - {1'b0, div_i}) : trial[DIV_W-1:0];
      num_d = {num_q[NUM_W-2:0], 1'b0};
      cnt_d = cnt_q + CntW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/csh_gold.sv =====
// serial length-31 gold sequence generator, one sequence bit per cycle
// depends on csh_pkg; skips a given number of bits, then packs the next eight lsb first
module csh_gold import csh_pkg::*; #(
  parameter int unsigned TOT_W = 15
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [IdentityW-1:0]    seed_i,
  input  logic [TOT_W-1:0]        skip_i,
  output logic                    done_o,
  output logic [BitsPerShift-1:0] bits_o
);

  localparam int unsigned BitCntW = $clog2(BitsPerShift);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [TOT_W-1:0]        skip_q, skip_d;
  logic [BitCntW-1:0]      bcnt_q, bcnt_d;
  logic [GoldLen-1:0]      x1_q, x1_d;
  logic [GoldLen-1:0]      x2_q, x2_d;
  logic [BitsPerShift-1:0] bits_q, bits_d;
  logic                    f1, f2;

  assign f1 = x1_q[3] ^ x1_q[0];
  assign f2 = x2_q[3] ^ x2_q[2] ^ x2_q[1] ^ x2_q[0];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    skip_d = skip_q;
    bcnt_d = bcnt_q;
    x1_d   = x1_q;
    x2_d   = x2_q;
    bits_d = bits_q;
    if (start_i) begin
      busy_d = 1'b1;
      skip_d = skip_i;
      bcnt_d = '0;
      x1_d   = GoldLen'(1);
      x2_d   = GoldLen'(seed_i);
    end else if (busy_q) begin
      x1_d = {f1, x1_q[GoldLen-1:1]};
      x2_d = {f2, x2_q[GoldLen-1:1]};
      if (skip_q != '0) begin
        skip_d = skip_q - TOT_W'(1);
      end else begin
        bits_d = {x1_q[0] ^ x2_q[0], bits_q[BitsPerShift-1:1]};
        bcnt_d = bcnt_q + BitCntW'(1);
        if (bcnt_q == BitCntW'(BitsPerShift - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      skip_q <= '0;
      bcnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      skip_q <= skip_d;
      bcnt_q <= bcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= x1_d;
    x2_q   <= x2_d;
    bits_q <= bits_d;
  end

  assign done_o = done_q;
  assign bits_o = bits_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking bench for cyclic_shift_hopping_index: corner and random words with random
// idling on both channels, checked against a gold sequence model kept in the bench
// depends on csh_pkg and the rtl of cyclic_shift_hopping_index
module tb_top;
  import csh_pkg::*;

  localparam logic [HopW-1:0] HOP_GROUP    = 2'd1;
  localparam logic [HopW-1:0] HOP_DISABLE  = 2'd2;
  localparam logic [HopW-1:0] HOP_RESERVED = 2'd3;

  localparam int unsigned MAX_IDLE    = 16;
  localparam int unsigned HOLD_AT     = 30;
  localparam int unsigned HOLD_CYCLES = 8000;
  localparam int unsigned TAIL_CYCLES = 2000;
  localparam int unsigned CYCLE_LIMIT = 10_000_000;

  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic [SymW-1:0]   symbol;
    logic [SymW-1:0]   start;
    logic [ShiftW-1:0] m0;
    logic [ShiftW-1:0] mcs;
  } shift_word_t;

  typedef struct packed {
    logic [ShiftW-1:0] alpha;
    logic [GroupW-1:0] group;
    logic              bsn;
    logic              status;
  } shift_result_t;

  class shift_tracker;
    logic [IdentityW-1:0] identity   = '0;
    logic [NumerW-1:0]    numerology = '0;
    logic [HopW-1:0]      hopping    = HOP_NEITHER;
    shift_result_t        pending_shifts[$];
    int unsigned          errors       = 0;
    int unsigned          results_seen = 0;

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_IDENTITY:   identity   = data[IdentityW-1:0];
        CFG_NUMEROLOGY: numerology = data[NumerW-1:0];
        CFG_HOPPING:    hopping    = data[HopW-1:0];
        default: ;
      endcase
    endfunction

    // eight sequence bits from the given position on, first bit in the lsb
    function logic [BitsPerShift-1:0] gold_byte(logic [IdentityW-1:0] seed,
                                                int unsigned offset);
      logic [GoldLen-1:0]      x1;
      logic [GoldLen-1:0]      x2;
      logic [BitsPerShift-1:0] bits;
      int unsigned             total;
      x1 = GoldLen'(1);
      x2 = GoldLen'(seed);
      bits = '0;
      total = GoldWarmup + offset;
      for (int unsigned n = 0; n < total + BitsPerShift; n++) begin
        if (n >= total) bits = {x1[0] ^ x2[0], bits[BitsPerShift-1:1]};
        x1 = {x1[3] ^ x1[0], x1[GoldLen-1:1]};
        x2 = {x2[3] ^ x2[2] ^ x2[1] ^ x2[0], x2[GoldLen-1:1]};
      end
      return bits;
    endfunction

    function void note_word(shift_word_t w);
      int unsigned   mu;
      int unsigned   n_slot;
      int unsigned   offset;
      int unsigned   sum;
      shift_result_t r;
      // numerology saturates at four
      mu = (numerology > MaxNumerology) ? MaxNumerology : numerology;
      n_slot = w.slot % (BaseSlots << mu);
      offset = BitsPerShift * (SymbolsPerSlotDef * n_slot + w.symbol + w.start);
      sum = w.m0 + w.mcs + gold_byte(identity, offset);
      r.alpha = ShiftW'(sum % ShiftModulus);
      r.bsn = 1'b0;
      if (hopping == HOP_NEITHER) begin
        r.group = GroupW'(identity % GroupCount);
        r.status = STATUS_OK;
      end else begin
        r.group = '0;
        r.status = STATUS_NOSUP;
      end
      pending_shifts.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_word(shift_result_t got);
      shift_result_t want;
      results_seen++;
      if (pending_shifts.size() == 0) begin
        report($sformatf("word with none pending, alpha %0d group %0d status %0d",
                         got.alpha, got.group, got.status));
        return;
      end
      want = pending_shifts.pop_front();
      if (got.alpha !== want.alpha)
        report($sformatf("alpha_index got %0d want %0d", got.alpha, want.alpha));
      if (got.group !== want.group)
        report($sformatf("group_number got %0d want %0d", got.group, want.group));
      if (got.bsn !== want.bsn)
        report($sformatf("base_sequence_number got %0d want %0d", got.bsn, want.bsn));
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SlotW-1:0]    slot_number_i;
  logic [SymW-1:0]     symbol_offset_i;
  logic [SymW-1:0]     start_symbol_i;
  logic [ShiftW-1:0]   initial_shift_i;
  logic [ShiftW-1:0]   shift_offset_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ShiftW-1:0]   alpha_index_o;
  logic [GroupW-1:0]   group_number_o;
  logic                base_sequence_number_o;
  logic                status_o;

  shift_tracker tracker = new;
  bit           calm_in = 1'b0;
  bit           calm_out = 1'b0;
  int unsigned  cycle_count = 0;

  cyclic_shift_hopping_index uut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .slot_number_i          (slot_number_i),
    .symbol_offset_i        (symbol_offset_i),
    .start_symbol_i         (start_symbol_i),
    .initial_shift_i        (initial_shift_i),
    .shift_offset_i         (shift_offset_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .alpha_index_o          (alpha_index_o),
    .group_number_o         (group_number_o),
    .base_sequence_number_o (base_sequence_number_o),
    .status_o               (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // entered and left at a falling edge; only legal while the block is idle
  task automatic configure(logic [IdentityW-1:0] ident, logic [NumerW-1:0] numer,
                           logic [HopW-1:0] hop);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_IDENTITY;
    cfg_data_i <= CfgDataW'(ident);
    @(negedge clk_i);
    cfg_idx_i <= CFG_NUMEROLOGY;
    cfg_data_i <= CfgDataW'(numer);
    @(negedge clk_i);
    cfg_idx_i <= CFG_HOPPING;
    cfg_data_i <= CfgDataW'(hop);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.write_reg(CFG_IDENTITY, CfgDataW'(ident));
    tracker.write_reg(CFG_NUMEROLOGY, CfgDataW'(numer));
    tracker.write_reg(CFG_HOPPING, CfgDataW'(hop));
  endtask

  // valid stays up into the next word when no gap follows
  task automatic send_word(shift_word_t w, bit more);
    int unsigned gap;
    slot_number_i <= w.slot;
    symbol_offset_i <= w.symbol;
    start_symbol_i <= w.start;
    initial_shift_i <= w.m0;
    shift_offset_i <= w.mcs;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.note_word(w);
    @(negedge clk_i);
    gap = (more && !calm_in) ? $urandom_range(0, MAX_IDLE) : 0;
    if (!more || gap > 0) in_valid_i <= 1'b0;
    repeat (gap) @(negedge clk_i);
  endtask

  task automatic run_phase(int ident, logic [NumerW-1:0] numer, logic [HopW-1:0] hop,
                           int unsigned count);
    shift_word_t          w;
    logic [IdentityW-1:0] id_value;
    while (tracker.pending_shifts.size() != 0) @(negedge clk_i);
    id_value = (ident < 0) ? IdentityW'($urandom_range(0, 1023)) : IdentityW'(ident);
    configure(id_value, numer, hop);
    calm_in = ($urandom_range(0, 3) == 0);
    calm_out = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < count; i++) begin
      w.slot = SlotW'($urandom_range(0, 16'hFFFF));
      w.symbol = SymW'($urandom_range(0, 15));
      w.start = SymW'($urandom_range(0, 15));
      w.m0 = ShiftW'($urandom_range(0, 15));
      w.mcs = ShiftW'($urandom_range(0, 15));
      send_word(w, i + 1 < count);
    end
  endtask

  initial begin : stimulus
    shift_word_t corner [16];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_IDENTITY;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    slot_number_i = '0;
    symbol_offset_i = '0;
    start_symbol_i = '0;
    initial_shift_i = '0;
    shift_offset_i = '0;
    // field extremes, slot wrap, symbols past the slot and shifts above eleven
    corner = '{
      '{16'h0000, 4'd0,  4'd0,  4'd0,  4'd0},
      '{16'hFFFF, 4'd15, 4'd15, 4'd15, 4'd15},
      '{16'h0009, 4'd13, 4'd13, 4'd11, 4'd11},
      '{16'h000A, 4'd0,  4'd0,  4'd0,  4'd0},
      '{16'h0000, 4'd15, 4'd0,  4'd0,  4'd0},
      '{16'h0000, 4'd0,  4'd15, 4'd0,  4'd0},
      '{16'h0001, 4'd13, 4'd0,  4'd15, 4'd0},
      '{16'h0002, 4'd0,  4'd13, 4'd0,  4'd15},
      '{16'h0003, 4'd7,  4'd7,  4'd12, 4'd12},
      '{16'h8000, 4'd1,  4'd2,  4'd3,  4'd4},
      '{16'h5555, 4'd5,  4'd10, 4'd5,  4'd10},
      '{16'hAAAA, 4'd10, 4'd5,  4'd10, 4'd5},
      '{16'h7FFF, 4'd14, 4'd14, 4'd11, 4'd0},
      '{16'hFFF6, 4'd3,  4'd8,  4'd0,  4'd11},
      '{16'h0001, 4'd1,  4'd1,  4'd1,  4'd1},
      '{16'h0013, 4'd0,  4'd0,  4'd15, 4'd15}
    };
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset configuration first
    foreach (corner[i]) send_word(corner[i], i + 1 < $size(corner));

    run_phase(1023, 3'd0, HOP_NEITHER, 22);
    run_phase(-1, 3'd1, HOP_GROUP, 16);
    run_phase(0, 3'd7, HOP_RESERVED, 5);
    run_phase(-1, 3'd4, HOP_DISABLE, 5);
    run_phase(-1, 3'd2, HOP_NEITHER, 16);
    run_phase(-1, 3'd3, HOP_NEITHER, 8);
    run_phase(30, 3'd5, HOP_NEITHER, 4);
    run_phase(-1, 3'd0, HOP_NEITHER, 20);

    while (tracker.pending_shifts.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : drain
    int unsigned   hold;
    shift_result_t got;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (tracker.results_seen == HOLD_AT) begin
        // long hold-off so the block backs up and stalls its input
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      hold = calm_out ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold == 0) begin
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 1) == 1) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        // stall runs on after the word shows up
        out_stall_i <= 1'b1;
        do @(posedge clk_i); while (out_valid_o !== 1'b1);
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
      got.alpha = alpha_index_o;
      got.group = group_number_o;
      got.bsn = base_sequence_number_o;
      got.status = status_o;
      tracker.check_word(got);
      @(negedge clk_i);
    end
  end

endmodule

// ===== filelist.f =====
src/csh_pkg.sv
src/csh_mod.sv
src/csh_gold.sv
src/cyclic_shift_hopping_index.sv
tb/tb_top.sv
